// File: rtl/mfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants for the motor feedback frame deframer.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int unsigned WindowBytes = 20;
  localparam int unsigned FrameWords  = 10;
  localparam int unsigned SignalWords = 8;
  localparam int unsigned FillWidth   = 5;
  localparam int unsigned AddrWidth   = 3;

  localparam logic [15:0] StartReset = 16'hABCD;

  // register index, taken from paddr[2]
  localparam logic RegStartWord = 1'b0;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [FillWidth-1:0] fill_t;

  // entry 0 oldest, entry WindowBytes-1 newest
  typedef byte_t [WindowBytes-1:0] window_t;
  typedef word_t [SignalWords-1:0] signals_t;

  typedef struct packed {
    logic    full;
    window_t bytes;
  } win_view_t;

  typedef struct packed {
    logic     hit;
    signals_t signals;
  } frame_match_t;

endpackage

// File: rtl/motor_feedback_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_frame_deframer_unit
// Finds XOR-16 checked feedback frames in a received byte stream and emits
// the eight signal words of each valid frame.
//
//   channel | dir | handshake                | payload
//   rx      | in  | rx_valid_i / rx_stall_o  | rx_byte_i
//   fb      | out | fb_valid_o / fb_stall_i  | command_one_o .. current_right_o
//   cfg     | in  | APB psel/penable/pready  | start_word at byte address 0
//
// One byte per cycle unless rx stalls; each frame is registered in the
// output register, or in the skid while fb stalls. The window shift and
// XOR check sit between the window register and the output register. A
// two-deep output stage (register plus skid) keeps rx open while one
// result waits; rx stalls only when both are full. Reset clears the fill
// count and the output stage, and sets start_word to 0xABCD.
// ----------------------------------------------------------------------------
module motor_feedback_frame_deframer_unit
  import mfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rx_valid_i,
  output logic                 rx_stall_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 fb_valid_o,
  input  logic                 fb_stall_i,
  output logic signed [15:0]   command_one_o,
  output logic signed [15:0]   command_two_o,
  output logic signed [15:0]   speed_right_o,
  output logic signed [15:0]   speed_left_o,
  output logic signed [15:0]   battery_voltage_o,
  output logic signed [15:0]   board_temperature_o,
  output logic signed [15:0]   current_left_o,
  output logic signed [15:0]   current_right_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  word_t        start_word_q;
  win_view_t    view;
  frame_match_t match;
  logic         rx_fire, fb_fire, new_res;

  signals_t out_q, skid_q;
  logic     out_valid_q, skid_valid_q;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_word_q <= StartReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegStartWord) begin
      start_word_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == RegStartWord) ? {16'h0000, start_word_q} : 32'h0;

  // datapath
  assign rx_stall_o = skid_valid_q;
  assign rx_fire    = rx_valid_i && !rx_stall_o;

  mfd_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (rx_fire),
    .rx_byte_i (rx_byte_i),
    .hit_i     (match.hit),
    .view_o    (view)
  );

  mfd_check u_check (
    .view_i       (view),
    .start_word_i (start_word_q),
    .match_o      (match)
  );

  assign new_res = rx_fire && match.hit;
  assign fb_fire = out_valid_q && !fb_stall_i;

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (!out_valid_q || fb_fire) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || fb_fire) begin
      out_valid_q <= new_res;
    end else if (new_res) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_valid_q || fb_fire) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || fb_fire) begin
      if (new_res) begin
        out_q <= match.signals;
      end
    end else if (new_res) begin
      skid_q <= match.signals;
    end
  end

  assign fb_valid_o          = out_valid_q;
  assign command_one_o       = signed'(out_q[0]);
  assign command_two_o       = signed'(out_q[1]);
  assign speed_right_o       = signed'(out_q[2]);
  assign speed_left_o        = signed'(out_q[3]);
  assign battery_voltage_o   = signed'(out_q[4]);
  assign board_temperature_o = signed'(out_q[5]);
  assign current_left_o      = signed'(out_q[6]);
  assign current_right_o     = signed'(out_q[7]);

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid full with output empty");
  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && fb_stall_i && new_res))
    else $error("skid filled without a stalled result");
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    new_res |=> out_valid_q) else $error("result lost");
`endif

endmodule

// File: rtl/mfd_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_window
// Twenty-byte shift window with fill count; presents the window as it stands
// once the incoming byte is shifted in.
// ----------------------------------------------------------------------------
module mfd_window
  import mfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  byte_t     rx_byte_i,
  input  logic      hit_i,
  output win_view_t view_o
);

  localparam fill_t FillFull = fill_t'(WindowBytes);
  localparam fill_t FillLast = fill_t'(WindowBytes - 1);

  window_t window_q, window_d;
  fill_t   fill_q, fill_d;

  always_comb begin
    for (int i = 0; i < WindowBytes - 1; i++) begin
      window_d[i] = window_q[i+1];
    end
    window_d[WindowBytes-1] = rx_byte_i;
  end

  assign view_o.bytes = window_d;
  assign view_o.full  = (fill_q >= FillLast);

  always_comb begin
    fill_d = fill_q;
    if (push_i) begin
      if (hit_i) begin
        fill_d = '0;
      end else if (fill_q >= FillLast) begin
        fill_d = FillFull;
      end else begin
        fill_d = fill_q + fill_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      window_q <= window_d;
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull) else $error("fill count out of range");
  a_hit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && hit_i |=> fill_q == '0) else $error("fill not cleared on frame");
  a_hit_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && hit_i |-> view_o.full) else $error("frame found in partial window");
`endif

endmodule

// File: rtl/mfd_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_check
// Start word and XOR check over the ten little-endian words of the window.
// ----------------------------------------------------------------------------
module mfd_check
  import mfd_pkg::*;
(
  input  win_view_t    view_i,
  input  word_t        start_word_i,
  output frame_match_t match_o
);

  word_t words [FrameWords];
  word_t xsum;

  always_comb begin
    for (int k = 0; k < FrameWords; k++) begin
      words[k] = {view_i.bytes[2*k+1], view_i.bytes[2*k]};
    end
  end

  always_comb begin
    xsum = '0;
    for (int k = 0; k < FrameWords - 1; k++) begin
      xsum = xsum ^ words[k];
    end
  end

  always_comb begin
    for (int k = 0; k < SignalWords; k++) begin
      match_o.signals[k] = words[k+1];
    end
  end

  assign match_o.hit = view_i.full && (words[0] == start_word_i)
                       && (xsum == words[FrameWords-1]);

endmodule
